// ===== rtl/core/gpi_pkg.sv =====
// Shared types, constants and register codes for the gradient palette interpolator.
`timescale 1ns / 1ps
`default_nettype none

package gpi_pkg;

  // Default parameter values
  localparam int INDEX_WIDTH_DEF = 12;
  localparam int MAX_STOPS_DEF   = 6;

  // Field widths
  localparam int PSIZE_W   = 13;
  localparam int SCOUNT_W  = 3;
  localparam int STOP_W    = 36;
  localparam int POS_W     = 12;
  localparam int CHAN_W    = 8;
  localparam int NCHAN     = 3;
  localparam int RGB_W     = NCHAN * CHAN_W;
  localparam int QUO_W     = 8;
  localparam int NUM_W     = POS_W + CHAN_W;
  localparam int CFG_ADDR_W = 3;
  localparam int COLOR_W   = 32;
  localparam int STATUS_W  = 2;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // Register reset values
  localparam logic [PSIZE_W-1:0]  PSIZE_RST  = 13'd256;
  localparam logic [SCOUNT_W-1:0] SCOUNT_RST = 3'd2;
  localparam logic [STOP_W-1:0]   STOP0_RST  = 36'h0_0000_0000;
  localparam logic [STOP_W-1:0]   STOP1_RST  = 36'h0_FFFF_FFFF;

  // Register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PALETTE_SIZE = 3'd0,
    REG_STOP_COUNT   = 3'd1,
    REG_STOP_0       = 3'd2,
    REG_STOP_1       = 3'd3,
    REG_STOP_2       = 3'd4,
    REG_STOP_3       = 3'd5,
    REG_STOP_4       = 3'd6,
    REG_STOP_5       = 3'd7
  } reg_addr_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BEYOND    = 2'd1,
    ST_BAD_STOPS = 2'd2,
    ST_CLAMP     = 2'd3
  } status_t;

  // Channel order: [2] red, [1] green, [0] blue
  typedef logic [NCHAN-1:0][CHAN_W-1:0] rgb_t;

  // Beat leaving the segment-select stage
  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    rgb_t             col_a;   // also carries the clamp color
    rgb_t             col_b;
  } seg_beat_t;

  // Beat moving along the divider cells
  typedef struct packed {
    status_t                        status;
    rgb_t                           color;
    logic [POS_W-1:0]               den;
    logic [NCHAN-1:0][NUM_W-1:0]    rem;
    logic [NCHAN-1:0][QUO_W-1:0]    quo;
  } div_beat_t;

endpackage

`default_nettype wire

// ===== rtl/core/gradient_palette_interpolator.sv =====
// Top level: config registers, front stages, divider cell chain, output register.
//
//  channel  | signals                          | payload
//  ---------+----------------------------------+-------------------------------------
//  in       | in_tvalid/in_tready/in_tdata     | palette_index
//  out      | out_tvalid/out_tready/out_tdata  | color_word; out_tuser = status
//  cfg      | cfg_wr_en/cfg_addr/cfg_wdata     | palette_size, stop_count, stop_0..5
//
// Throughput is one index per cycle while out_tready is high. Stages: segment select, weight
// multiply, eight divider cells (one quotient bit each) and the output register.
// Every stage has its own valid and holds its beat on a stall, so empty stages keep
// filling while a finished result waits at the output.
// Reset (rst_n low, synchronous) clears all valid bits and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module gradient_palette_interpolator #(
  parameter int INDEX_WIDTH = gpi_pkg::INDEX_WIDTH_DEF,
  parameter int MAX_STOPS   = gpi_pkg::MAX_STOPS_DEF,
  parameter int IN_TDATA_W  = ((INDEX_WIDTH + 7) / 8) * 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  input  wire logic [IN_TDATA_W-1:0]              in_tdata,   // palette_index
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  output      logic [gpi_pkg::COLOR_W-1:0]        out_tdata,  // color_word
  output      logic [gpi_pkg::STATUS_W-1:0]       out_tuser,  // status
  input  wire logic                               cfg_wr_en,
  input  wire logic [gpi_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [gpi_pkg::STOP_W-1:0]         cfg_wdata
);
  import gpi_pkg::*;

  logic [PSIZE_W-1:0]                 palette_size_r;
  logic [SCOUNT_W-1:0]                stop_count_r;
  logic [MAX_STOPS-1:0][STOP_W-1:0]   stops_r;

  logic        seg_valid;
  seg_beat_t   seg_data;
  logic        seg_ready;
  logic        mul_ready;

  logic        div_valid [QUO_W+1];
  div_beat_t   div_data  [QUO_W+1];
  logic        div_ready [QUO_W+1];

  logic             out_valid_r;
  logic [COLOR_W-1:0] out_color_r;
  status_t          out_status_r;
  logic [COLOR_W-1:0] color_nxt;
  logic             out_load;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_size_r <= PSIZE_RST;
      stop_count_r   <= SCOUNT_RST;
      for (int k = 0; k < MAX_STOPS; k++) begin
        stops_r[k] <= (k == 1) ? STOP1_RST : STOP0_RST;
      end
    end else if (cfg_wr_en) begin
      if (cfg_addr == REG_PALETTE_SIZE) begin
        palette_size_r <= cfg_wdata[PSIZE_W-1:0];
      end
      if (cfg_addr == REG_STOP_COUNT) begin
        stop_count_r <= cfg_wdata[SCOUNT_W-1:0];
      end
      for (int k = 0; k < MAX_STOPS; k++) begin
        if (cfg_addr == CFG_ADDR_W'(int'(REG_STOP_0) + k)) begin
          stops_r[k] <= cfg_wdata;
        end
      end
    end
  end

  gpi_seg_stage #(
    .INDEX_WIDTH (INDEX_WIDTH),
    .MAX_STOPS   (MAX_STOPS)
  ) u_seg (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid_i        (in_tvalid),
    .index_i        (in_tdata[INDEX_WIDTH-1:0]),
    .ready_o        (seg_ready),
    .palette_size_i (palette_size_r),
    .stop_count_i   (stop_count_r),
    .stops_i        (stops_r),
    .valid_o        (seg_valid),
    .data_o         (seg_data),
    .ready_i        (mul_ready)
  );

  assign in_tready = seg_ready;

  gpi_mul_stage u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (seg_valid),
    .data_i  (seg_data),
    .ready_o (mul_ready),
    .valid_o (div_valid[0]),
    .data_o  (div_data[0]),
    .ready_i (div_ready[0])
  );

  // Divider chain, most significant quotient bit first
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    gpi_div_cell #(
      .BIT (QUO_W - 1 - j)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (div_valid[j]),
      .data_i  (div_data[j]),
      .ready_o (div_ready[j]),
      .valid_o (div_valid[j+1]),
      .data_o  (div_data[j+1]),
      .ready_i (div_ready[j+1])
    );
  end

  // Output register
  assign div_ready[QUO_W] = !out_valid_r || out_tready;
  assign out_load         = div_ready[QUO_W] && div_valid[QUO_W];

  always_comb begin
    case (div_data[QUO_W].status)
      ST_OK:    color_nxt = {ALPHA_OPAQUE, div_data[QUO_W].quo[2],
                             div_data[QUO_W].quo[1], div_data[QUO_W].quo[0]};
      ST_CLAMP: color_nxt = {ALPHA_OPAQUE, div_data[QUO_W].color};
      default:  color_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_ready[QUO_W]) begin
      out_valid_r <= div_valid[QUO_W];
    end
    if (out_load) begin
      out_color_r  <= color_nxt;
      out_status_r <= div_data[QUO_W].status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_color_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/core/gpi_seg_stage.sv =====
// Front stage: range and order checks, segment select, bracketing stop fetch.
`timescale 1ns / 1ps
`default_nettype none

module gpi_seg_stage #(
  parameter int INDEX_WIDTH = gpi_pkg::INDEX_WIDTH_DEF,
  parameter int MAX_STOPS   = gpi_pkg::MAX_STOPS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   valid_i,
  input  wire logic [INDEX_WIDTH-1:0]                 index_i,
  output      logic                                   ready_o,
  input  wire logic [gpi_pkg::PSIZE_W-1:0]            palette_size_i,
  input  wire logic [gpi_pkg::SCOUNT_W-1:0]           stop_count_i,
  input  wire logic [MAX_STOPS-1:0][gpi_pkg::STOP_W-1:0] stops_i,
  output      logic                                   valid_o,
  output      gpi_pkg::seg_beat_t                     data_o,
  input  wire logic                                   ready_i
);
  import gpi_pkg::*;

  localparam int CW    = (INDEX_WIDTH > PSIZE_W) ? INDEX_WIDTH : PSIZE_W;
  localparam int SEG_W = (MAX_STOPS > 2) ? $clog2(MAX_STOPS) : 1;

  logic                  valid_r;
  seg_beat_t             data_r;
  seg_beat_t             data_nxt;
  logic [CW-1:0]         idx_ext;
  logic [SCOUNT_W-1:0]   n_use;
  logic [POS_W-1:0]      pos [MAX_STOPS];
  logic                  bad;
  logic [STOP_W-1:0]     last_stop;
  logic                  clamp;
  logic [SEG_W-1:0]      seg;
  logic [STOP_W-1:0]     stop_a;
  logic [STOP_W-1:0]     stop_b;

  assign idx_ext = CW'(index_i);
  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  // Clamp the stop count into 2..MAX_STOPS
  always_comb begin
    if (stop_count_i < 3'd2) begin
      n_use = 3'd2;
    end else if (stop_count_i > SCOUNT_W'(MAX_STOPS)) begin
      n_use = SCOUNT_W'(MAX_STOPS);
    end else begin
      n_use = stop_count_i;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_STOPS; k++) begin
      pos[k] = stops_i[k][STOP_W-1 -: POS_W];
    end
  end

  // Order check, last stop, segment search and stop fetch
  always_comb begin
    bad = (pos[0] != '0);
    for (int k = 1; k < MAX_STOPS; k++) begin
      if (SCOUNT_W'(k) < n_use && pos[k] <= pos[k-1]) begin
        bad = 1'b1;
      end
    end

    last_stop = stops_i[0];
    for (int k = 0; k < MAX_STOPS; k++) begin
      if (SCOUNT_W'(k) == n_use - 3'd1) begin
        last_stop = stops_i[k];
      end
    end
    clamp = (idx_ext >= CW'(last_stop[STOP_W-1 -: POS_W]));

    // If sorted (else flagged bad), the last inner stop passed is the segment start
    seg = '0;
    for (int k = 1; k < MAX_STOPS - 1; k++) begin
      if (SCOUNT_W'(k + 1) < n_use && idx_ext >= CW'(pos[k])) begin
        seg = SEG_W'(k);
      end
    end

    stop_a = stops_i[0];
    stop_b = stops_i[1];
    for (int k = 0; k < MAX_STOPS; k++) begin
      if (k == int'(seg)) begin
        stop_a = stops_i[k];
      end
      if (k == int'(seg) + 1) begin
        stop_b = stops_i[k];
      end
    end
  end

  // Assemble the outgoing beat with flag priority
  always_comb begin
    data_nxt.idx   = POS_W'(index_i);
    data_nxt.pos_a = stop_a[STOP_W-1 -: POS_W];
    data_nxt.pos_b = stop_b[STOP_W-1 -: POS_W];
    data_nxt.col_a = stop_a[RGB_W-1:0];
    data_nxt.col_b = stop_b[RGB_W-1:0];
    if (idx_ext >= CW'(palette_size_i)) begin
      data_nxt.status = ST_BEYOND;
    end else if (bad) begin
      data_nxt.status = ST_BAD_STOPS;
    end else if (clamp) begin
      data_nxt.status = ST_CLAMP;
      data_nxt.col_a  = last_stop[RGB_W-1:0];
    end else begin
      data_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gpi_mul_stage.sv =====
// Weight stage: distances to both stops and the per-channel weighted sums.
`timescale 1ns / 1ps
`default_nettype none

module gpi_mul_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               valid_i,
  input  wire gpi_pkg::seg_beat_t data_i,
  output      logic               ready_o,
  output      logic               valid_o,
  output      gpi_pkg::div_beat_t data_o,
  input  wire logic               ready_i
);
  import gpi_pkg::*;

  logic             valid_r;
  div_beat_t        data_r;
  div_beat_t        data_nxt;
  logic [POS_W-1:0] d0;
  logic [POS_W-1:0] nd1;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  // num = d0*c1 + (p1-i)*c0, at most 255*d, so the quotient fits 8 bits
  always_comb begin
    d0  = data_i.idx - data_i.pos_a;
    nd1 = data_i.pos_b - data_i.idx;
    data_nxt.status = data_i.status;
    data_nxt.color  = data_i.col_a;
    data_nxt.den    = data_i.pos_b - data_i.pos_a;
    data_nxt.quo    = '0;
    for (int c = 0; c < NCHAN; c++) begin
      data_nxt.rem[c] = NUM_W'(d0) * NUM_W'(data_i.col_b[c])
                      + NUM_W'(nd1) * NUM_W'(data_i.col_a[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gpi_div_cell.sv =====
// Divider cell: settles one quotient bit for all three channels.
`timescale 1ns / 1ps
`default_nettype none

module gpi_div_cell #(
  parameter int BIT = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               valid_i,
  input  wire gpi_pkg::div_beat_t data_i,
  output      logic               ready_o,
  output      logic               valid_o,
  output      gpi_pkg::div_beat_t data_o,
  input  wire logic               ready_i
);
  import gpi_pkg::*;

  logic             valid_r;
  div_beat_t        data_r;
  div_beat_t        data_nxt;
  logic [NUM_W-1:0] trial;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  // Restoring step: subtract the shifted divisor where it fits
  always_comb begin
    trial    = NUM_W'(data_i.den) << BIT;
    data_nxt = data_i;
    for (int c = 0; c < NCHAN; c++) begin
      if (data_i.rem[c] >= trial) begin
        data_nxt.rem[c]      = data_i.rem[c] - trial;
        data_nxt.quo[c][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gpi_checker.sv =====
// Port-level checker for the gradient palette interpolator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gpi_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [gpi_pkg::COLOR_W-1:0]  out_tdata,
  input wire logic [gpi_pkg::STATUS_W-1:0] out_tuser
);
  import gpi_pkg::*;

  // Error beats carry no color
  a_err_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_BEYOND || out_tuser == ST_BAD_STOPS)
    |-> out_tdata == '0)
    else $error("error beat carries a nonzero color");

  // Good and clamped beats are opaque
  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_OK || out_tuser == ST_CLAMP)
    |-> out_tdata[COLOR_W-1 -: CHAN_W] == ALPHA_OPAQUE)
    else $error("color beat is not opaque");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat valid right after reset");

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

endmodule

bind gradient_palette_interpolator gpi_checker u_gpi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
